>>> hw/rtl/mbps_pkg.sv
// mbps_pkg: shared types and constants for the masked byte pattern search
// holds register codes, fixed field widths and the item / result structs
// no dependencies
`default_nettype none

package mbps_pkg;

  // fixed field widths
  localparam int PATTERN_BYTES  = 32;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 3;
  localparam int MASK_W         = 32;
  localparam int LEN_REG_W      = 6;
  localparam int MATCH_OFFSET_W = 32;
  localparam int SEG_INDEX_W    = 8;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_WORD0   = 3'd0,
    CFG_PATTERN_WORD1   = 3'd1,
    CFG_PATTERN_WORD2   = 3'd2,
    CFG_PATTERN_WORD3   = 3'd3,
    CFG_WILDCARD_MASK   = 3'd4,
    CFG_PATTERN_LENGTH  = 3'd5,
    CFG_FIRST_ONLY      = 3'd6
  } mbps_cfg_e;

  // one input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       segment_start;
    logic       scan_start;
    logic       scan_end;
  } mbps_item_t;

  // one result beat
  typedef struct packed {
    logic [SEG_INDEX_W-1:0]    segment_index;
    logic [MATCH_OFFSET_W-1:0] match_offset;
    logic                      no_match;
  } mbps_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/mbps_match.sv
// mbps_match: byte history window and parallel masked pattern compare
// uses mbps_pkg for the item struct and pattern width
`default_nettype none

module mbps_match
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 32,
  parameter int LEN_W       = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire mbps_item_t                    item,
  input  wire logic [PATTERN_BYTES-1:0][7:0] pattern,
  input  wire logic [MASK_W-1:0]             wildcard_mask,
  input  wire logic [LEN_W-1:0]              len,
  output logic                               hit_raw
);

  localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

  logic [7:0]       window [WIN_DEPTH];
  logic             seg_eff;
  logic [LEN_W-1:0] back_dist;
  logic [7:0]       sel;

  assign seg_eff = item.segment_start | item.scan_start;

  // window shift, newest byte first, cleared at a segment start
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WIN_DEPTH; k++) window[k] <= '0;
    end else if (step) begin
      window[0] <= item.data_byte;
      for (int k = 1; k < WIN_DEPTH; k++) begin
        window[k] <= seg_eff ? 8'd0 : window[k-1];
      end
    end
  end

  // each pattern byte picks the byte at its distance back and compares
  always_comb begin
    hit_raw   = (len != '0);
    back_dist = '0;
    sel       = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if ((LEN_W'(j) < len) && !wildcard_mask[j]) begin
        back_dist = LEN_W'(int'(len) - 1 - j);
        sel       = item.data_byte;
        for (int k = 0; k < WIN_DEPTH; k++) begin
          if (back_dist == LEN_W'(k + 1)) sel = seg_eff ? 8'd0 : window[k];
        end
        if (sel != pattern[j]) hit_raw = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mbps_track.sv
// mbps_track: segment offset, segment number and found flag; builds the result
// uses mbps_pkg for the item and result structs
`default_nettype none

module mbps_track
  import mbps_pkg::*;
#(
  parameter int OFFSET_BITS   = 32,
  parameter int SEGMENT_COUNT = 256,
  parameter int LEN_W         = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire mbps_item_t       item,
  input  wire logic [LEN_W-1:0] len,
  input  wire logic             first_only,
  input  wire logic             hit_raw,
  output logic                  res_valid,
  output mbps_result_t          result
);

  localparam int SEG_W = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;

  logic [OFFSET_BITS-1:0]    position;
  logic [SEG_W-1:0]          seg_count;
  logic                      found_any;

  logic                      seg_eff;
  logic [OFFSET_BITS-1:0]    pos_eff;
  logic [SEG_W-1:0]          seg_eff_count;
  logic                      found_eff;
  logic [LEN_W-1:0]          len_m1;
  logic                      report;
  logic                      not_found;
  logic [OFFSET_BITS-1:0]    start_pos;
  logic [MATCH_OFFSET_W-1:0] offset_out;
  logic [SEG_INDEX_W-1:0]    seg_out;

  assign seg_eff = item.segment_start | item.scan_start;

  // counters as seen by the current byte
  always_comb begin
    pos_eff   = seg_eff ? '0 : position;
    found_eff = item.scan_start ? 1'b0 : found_any;
    if (item.scan_start) begin
      seg_eff_count = '0;
    end else if (item.segment_start && (seg_count < SEG_W'(SEGMENT_COUNT - 1))) begin
      seg_eff_count = seg_count + 1'b1;
    end else begin
      seg_eff_count = seg_count;
    end
  end

  // match needs a full pattern length inside the segment
  assign len_m1    = len - 1'b1;
  assign start_pos = pos_eff - OFFSET_BITS'(len_m1);
  assign report    = hit_raw && (pos_eff >= OFFSET_BITS'(len_m1)) &&
                     !(first_only && found_eff);
  assign not_found = !report && item.scan_end && !found_eff;

  // fit the start offset and segment number into the result fields
  if (OFFSET_BITS >= MATCH_OFFSET_W) begin : g_off_trunc
    assign offset_out = start_pos[MATCH_OFFSET_W-1:0];
  end else begin : g_off_ext
    assign offset_out = {{(MATCH_OFFSET_W - OFFSET_BITS){1'b0}}, start_pos};
  end

  if (SEG_W >= SEG_INDEX_W) begin : g_seg_trunc
    assign seg_out = seg_eff_count[SEG_INDEX_W-1:0];
  end else begin : g_seg_ext
    assign seg_out = {{(SEG_INDEX_W - SEG_W){1'b0}}, seg_eff_count};
  end

  // result for this byte
  always_comb begin
    res_valid            = report | not_found;
    result.match_offset  = report ? offset_out : '0;
    result.segment_index = report ? seg_out : '0;
    result.no_match      = !report;
  end

  // state update, offset saturates at all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      seg_count <= '0;
      found_any <= 1'b0;
    end else if (step) begin
      position  <= (pos_eff != '1) ? pos_eff + 1'b1 : pos_eff;
      seg_count <= seg_eff_count;
      found_any <= report | found_eff;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/masked_byte_pattern_search.sv
// masked_byte_pattern_search: top level, config registers and beat registers
// m_tvalid comes from the result register, loaded as the byte held in the input register advances
// throughput: one byte per cycle while the result is not stalled; the masked compare is one parallel pass
// a byte held in the input register waits only while a result is stalled
// reset (rst, synchronous): clears config, window, counters and both valids
`default_nettype none

module masked_byte_pattern_search
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX   = 32,
  parameter int OFFSET_BITS   = 32,
  parameter int SEGMENT_COUNT = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // [7:0] data_byte
  input  wire logic [1:0]             s_tuser,   // [0] segment_start, [1] scan_start
  input  wire logic                   s_tlast,   // scan_end
  // result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [39:0]                 m_tdata,   // [31:0] match_offset, [39:32] segment_index
  output logic                        m_tuser,   // [0] no_match
  // configuration writes
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_BYTES-1:0][7:0] pattern;
  logic [MASK_W-1:0]             wildcard_mask;
  logic [LEN_REG_W-1:0]          pattern_length;
  logic                          first_only;
  logic [LEN_W-1:0]              len;

  logic                          in_valid;
  mbps_item_t                    in_item;
  logic                          advance;
  logic                          hit_raw;
  logic                          res_valid;
  mbps_result_t                  res;
  logic                          out_valid;
  mbps_result_t                  out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      wildcard_mask  <= '0;
      pattern_length <= '0;
      first_only     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATTERN_WORD0:  pattern[7:0]   <= cfg_data;
        CFG_PATTERN_WORD1:  pattern[15:8]  <= cfg_data;
        CFG_PATTERN_WORD2:  pattern[23:16] <= cfg_data;
        CFG_PATTERN_WORD3:  pattern[31:24] <= cfg_data;
        CFG_WILDCARD_MASK:  wildcard_mask  <= cfg_data[MASK_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_REG_W-1:0];
        CFG_FIRST_ONLY:     first_only     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // lengths above PATTERN_MAX act as PATTERN_MAX
  assign len = (pattern_length > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : LEN_W'(pattern_length);

  // handshake: the held byte moves on when the result register can take it
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.data_byte     <= s_tdata;
      in_item.segment_start <= s_tuser[0];
      in_item.scan_start    <= s_tuser[1];
      in_item.scan_end      <= s_tlast;
    end
  end

  mbps_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_match (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (in_item),
    .pattern       (pattern),
    .wildcard_mask (wildcard_mask),
    .len           (len),
    .hit_raw       (hit_raw)
  );

  mbps_track #(
    .OFFSET_BITS   (OFFSET_BITS),
    .SEGMENT_COUNT (SEGMENT_COUNT),
    .LEN_W         (LEN_W)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (in_item),
    .len        (len),
    .first_only (first_only),
    .hit_raw    (hit_raw),
    .res_valid  (res_valid),
    .result     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.segment_index, out_res.match_offset};
  assign m_tuser  = out_res.no_match;

  // a not-found result carries zero offset and segment
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("not-found result with nonzero fields");

  // an accepted beat always lands in the input register
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted beat lost");

  // input side only blocks behind a held byte and a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a stalled result");

  // a byte with no result leaves the result side empty once drained
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (advance && !res_valid) |=> !m_tvalid)
    else $error("result shown for a byte that gives none");

endmodule

`default_nettype wire
